FILE: hw/rtl/isort_pkg.sv
// Package for the insertion sorter: default parameters, output constants and
// the command and status structs shared by the controller and the datapath.
// Depends on nothing.
`timescale 1ns / 1ps

package isort_pkg;

    localparam int MAX_ELEMENTS_DEF = 16;
    localparam int VALUE_WIDTH_DEF  = 32;

    localparam int PASS_W = 4;
    localparam logic [PASS_W-1:0] PASS_MAX = 4'd15;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // insert the input value into the store this cycle
        logic emit;    // put one result on the outputs this cycle
        logic finish;  // this result ends the run; clear count and flag
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic final_out;  // the result shown this cycle is the last one
    } sts_t;

endpackage

FILE: hw/rtl/isort_ctrl.sv
// Controller of the insertion sorter: a two-state machine that accepts
// items while collecting and sequences the emission of results.
// Depends on isort_pkg.
`timescale 1ns / 1ps

module isort_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              carries_value,
    input  logic              is_last,
    input  isort_pkg::sts_t   sts,
    output isort_pkg::cmd_t   cmd,
    output logic              busy
);

    typedef enum logic {
        ST_COLLECT,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   busy_next;
    logic   accept;

    assign accept = start && !busy_reg;

    always_comb
    begin
        state_next = state_reg;
        busy_next  = busy_reg;
        case (state_reg)
            ST_COLLECT:
            begin
                if (accept && is_last)
                begin
                    state_next = ST_EMIT;
                    busy_next  = 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (sts.final_out)
                begin
                    state_next = ST_COLLECT;
                    busy_next  = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_COLLECT;
                busy_next  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_COLLECT;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
        end
    end

    assign cmd.load   = accept && carries_value;
    assign cmd.emit   = (state_reg == ST_EMIT);
    assign cmd.finish = (state_reg == ST_EMIT) && sts.final_out;
    assign busy       = busy_reg;

endmodule

FILE: hw/rtl/isort_dp.sv
// Datapath of the insertion sorter: a compare-and-shift register array that
// inserts one value per cycle while loading and shifts toward entry zero while emitting.
// Depends on isort_pkg.
`timescale 1ns / 1ps

module isort_dp
#(
    parameter int MAX_ELEMENTS = isort_pkg::MAX_ELEMENTS_DEF,
    parameter int VALUE_WIDTH  = isort_pkg::VALUE_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  isort_pkg::cmd_t               cmd,
    input  logic [VALUE_WIDTH-1:0]        value,
    output isort_pkg::sts_t               sts,
    output logic [VALUE_WIDTH-1:0]        sorted_value,
    output logic                          has_element,
    output logic                          final_result,
    output logic [isort_pkg::PASS_W-1:0]  pass_count,
    output logic                          overflowed
);

    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
    localparam int IDX_W = $clog2(MAX_ELEMENTS);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_ELEMENTS);

    logic [VALUE_WIDTH-1:0] store_reg  [MAX_ELEMENTS];
    logic [VALUE_WIDTH-1:0] store_next [MAX_ELEMENTS];
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic                   ovf_reg;
    logic                   ovf_next;
    logic [IDX_W-1:0]       idx_reg;
    logic [IDX_W-1:0]       idx_next;
    logic [MAX_ELEMENTS-1:0] gt;
    logic                   full;
    logic                   last_out;
    logic [31:0]            cnt_ext;
    logic [31:0]            pass_ext;

    assign full = (count_reg == CNT_FULL);

    // Each held entry compares itself against the new value in parallel.
    always_comb
    begin
        for (int i = 0; i < MAX_ELEMENTS; i++)
        begin
            gt[i] = (CNT_W'(i) < count_reg) && ($signed(store_reg[i]) > $signed(value));
        end
    end

    always_comb
    begin
        for (int i = 0; i < MAX_ELEMENTS; i++)
        begin
            store_next[i] = store_reg[i];
            if (cmd.emit)
            begin
                if (i < MAX_ELEMENTS - 1)
                begin
                    store_next[i] = store_reg[i + 1];
                end
            end
            else if (cmd.load && !full)
            begin
                if (i > 0 && gt[i - 1])
                begin
                    store_next[i] = store_reg[i - 1];
                end
                else if (gt[i] || (CNT_W'(i) == count_reg))
                begin
                    store_next[i] = value;
                end
            end
        end
    end

    assign last_out = (count_reg == '0) || ((CNT_W'(idx_reg) + 1'b1) == count_reg);

    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        idx_next   = idx_reg;
        if (cmd.finish)
        begin
            count_next = '0;
            ovf_next   = 1'b0;
            idx_next   = '0;
        end
        else if (cmd.emit)
        begin
            idx_next = idx_reg + 1'b1;
        end
        else if (cmd.load)
        begin
            if (full)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_ELEMENTS; i++)
        begin
            store_reg[i] <= store_next[i];
        end
    end

    // Pass count is elements minus one, zero below two, saturated.
    assign cnt_ext  = 32'(count_reg);
    assign pass_ext = (cnt_ext < 32'd2) ? 32'd0 :
                      ((cnt_ext - 32'd1) > 32'(isort_pkg::PASS_MAX)) ?
                      32'(isort_pkg::PASS_MAX) : (cnt_ext - 32'd1);

    assign sts.final_out = last_out;
    assign has_element   = (count_reg != '0);
    assign sorted_value  = (count_reg != '0) ? store_reg[0] : '0;
    assign final_result  = last_out;
    assign pass_count    = pass_ext[isort_pkg::PASS_W-1:0];
    assign overflowed    = ovf_reg;

endmodule

FILE: hw/rtl/insertion_sorter.sv
// Top level of the insertion sorter: joins the controller and the datapath.
// Depends on isort_pkg, isort_ctrl and isort_dp.
//
// Usage. An item transfer happens at a rising edge where start is high and
// busy is low; value, carries_value and is_last are sampled there. Items of a
// set may come in every cycle: each one is inserted into the sorted register
// array in the cycle it is taken, since all entries compare against the new
// value at once and the larger ones shift up by one place.
// An item with is_last high ends the set. From the next cycle busy is high
// and the results follow, one per cycle with strobe high for that single
// cycle, in ascending order; final_result marks the last one. Busy drops
// in the cycle after the final result. An empty set yields one result with
// has_element low. Values that arrive while the store is full are dropped
// and overflowed is raised on every result of that set. The receiver cannot
// stall: each result is valid only while strobe is high. Reset empties the
// store and clears the overflow flag; the stored values themselves are not
// cleared, as only counted entries are ever read.
`timescale 1ns / 1ps

module insertion_sorter
#(
    parameter int MAX_ELEMENTS = isort_pkg::MAX_ELEMENTS_DEF,
    parameter int VALUE_WIDTH  = isort_pkg::VALUE_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [VALUE_WIDTH-1:0]        value,
    input  logic                          carries_value,
    input  logic                          is_last,
    output logic                          strobe,
    output logic [VALUE_WIDTH-1:0]        sorted_value,
    output logic                          has_element,
    output logic                          final_result,
    output logic [isort_pkg::PASS_W-1:0]  pass_count,
    output logic                          overflowed
);

    isort_pkg::cmd_t cmd;
    isort_pkg::sts_t sts;

    isort_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .carries_value (carries_value),
        .is_last       (is_last),
        .sts           (sts),
        .cmd           (cmd),
        .busy          (busy)
    );

    isort_dp
    #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .VALUE_WIDTH  (VALUE_WIDTH)
    )
    u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .value        (value),
        .sts          (sts),
        .sorted_value (sorted_value),
        .has_element  (has_element),
        .final_result (final_result),
        .pass_count   (pass_count),
        .overflowed   (overflowed)
    );

    // A result is shown in every emission cycle.
    assign strobe = cmd.emit;

`ifndef SYNTHESIS
    // Taking the last item of a set starts the emission in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && is_last) |=> strobe)
        else $error("emission did not follow the last item");

    // Results stay back to back until the final one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !final_result) |=> strobe)
        else $error("gap in the result sequence");

    // After the final result the block takes items again.
    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && final_result) |=> (!busy && !strobe))
        else $error("block still busy after the final result");

    // A result without an element only ever stands alone.
    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !has_element) |-> (final_result && pass_count == '0))
        else $error("empty result inside a run");
`endif

endmodule

FILE: sim/tb_insertion_sorter.sv
// Self-checking testbench for the insertion sorter: drives sets of signed values and checks
// every sorted result against a predictor kept inside this file.
// Depends on isort_pkg and the insertion_sorter RTL.
`timescale 1ns / 1ps

module tb_insertion_sorter;

    localparam int CAPACITY     = isort_pkg::MAX_ELEMENTS_DEF;
    localparam int VW           = isort_pkg::VALUE_WIDTH_DEF;
    localparam int RANDOM_ITEMS = 250;
    // Cycles without any transfer before the run is declared hung.
    localparam int STALL_LIMIT  = 2000;
    // Cycles allowed after the last expected result, to catch stray strobes.
    localparam int TAIL_CYCLES  = 20;

    // One sorted result as the block presents it on its output ports.
    typedef struct packed {
        logic [VW-1:0]                sorted_value;
        logic                         has_element;
        logic                         final_result;
        logic [isort_pkg::PASS_W-1:0] pass_count;
        logic                         overflowed;
    } sorted_result_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         start = 1'b0;
    logic                         busy;
    logic [VW-1:0]                value = '0;
    logic                         carries_value = 1'b0;
    logic                         is_last = 1'b0;
    logic                         strobe;
    logic [VW-1:0]                sorted_value;
    logic                         has_element;
    logic                         final_result;
    logic [isort_pkg::PASS_W-1:0] pass_count;
    logic                         overflowed;

    // Predictor state: the values of the open set in ascending order, and whether any
    // value of that set was dropped because the store was full.
    logic signed [VW-1:0] sort_store[$];
    logic                 set_overflow = 1'b0;

    // Results that the block still owes, oldest first.
    sorted_result_t pending_sorted[$];

    int mismatches = 0;
    int burst_left = 0;
    int idle_cycles = 0;

    insertion_sorter i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .value         (value),
        .carries_value (carries_value),
        .is_last       (is_last),
        .strobe        (strobe),
        .sorted_value  (sorted_value),
        .has_element   (has_element),
        .final_result  (final_result),
        .pass_count    (pass_count),
        .overflowed    (overflowed)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Applies one accepted item to the predictor. A value is inserted above every entry
    // that is not strictly larger, so equal values keep their arrival order. When the
    // item closes the set, the whole store is queued as expected results and cleared.
    task automatic predict_sorted_set(input logic [VW-1:0] v, input logic cv,
                                      input logic last);
        int                           j;
        int                           n;
        logic [isort_pkg::PASS_W-1:0] passes;
        sorted_result_t               r;
        if (cv)
        begin
            if (sort_store.size() >= CAPACITY)
            begin
                set_overflow = 1'b1;
            end
            else
            begin
                j = sort_store.size();
                while (j > 0 && sort_store[j-1] > $signed(v))
                begin
                    j--;
                end
                sort_store.insert(j, $signed(v));
            end
        end
        if (last)
        begin
            n = sort_store.size();
            passes = (n < 2) ? '0 :
                     ((n - 1 > isort_pkg::PASS_MAX) ? isort_pkg::PASS_MAX :
                      isort_pkg::PASS_W'(n - 1));
            if (n == 0)
            begin
                // An empty set still gives one result, without an element.
                r = '{sorted_value: '0, has_element: 1'b0, final_result: 1'b1,
                      pass_count: '0, overflowed: set_overflow};
                pending_sorted.push_back(r);
            end
            for (int i = 0; i < n; i++)
            begin
                r = '{sorted_value: sort_store[i], has_element: 1'b1,
                      final_result: (i == n - 1), pass_count: passes,
                      overflowed: set_overflow};
                pending_sorted.push_back(r);
            end
            sort_store.delete();
            set_overflow = 1'b0;
        end
    endtask

    // Offers one item and holds it until the block takes it. The sender works in bursts:
    // when a burst runs out, start may drop for a few cycles before the next one begins.
    // Start stays high while busy, so items offered during the emission must be held off.
    task automatic send_item(input logic [VW-1:0] v, input logic cv, input logic last);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            if ($urandom_range(0, 3) != 0)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
        burst_left--;
        start         <= 1'b1;
        value         <= v;
        carries_value <= cv;
        is_last       <= last;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        predict_sorted_set(v, cv, last);
    endtask

    // Stops sending until every owed result has come out.
    task automatic wait_drained();
        start <= 1'b0;
        burst_left = 0;
        do
        begin
            @(posedge clk);
        end
        while (pending_sorted.size() != 0);
    endtask

    // Mostly full-range values, but often a narrow band around zero so that equal values
    // and sign changes turn up within one set, and now and then the two extremes.
    function automatic logic [VW-1:0] random_value();
        case ($urandom_range(0, 9)) inside
            [0:5]:   return $urandom;
            [6:7]:   return VW'($signed($urandom_range(0, 8)) - 4);
            8:       return {1'b1, {(VW-1){1'b0}}};
            default: return {1'b0, {(VW-1){1'b1}}};
        endcase
    endfunction

    // An empty set, both plain and after an ignored item without a value.
    task automatic test_empty_set();
        send_item(32'hDEADBEEF, 1'b0, 1'b1);
        send_item(32'h12345678, 1'b0, 1'b0);
        send_item(32'h0BADF00D, 1'b0, 1'b1);
        wait_drained();
    endtask

    // A single value that closes its own set: pass count must stay zero.
    task automatic test_single_value();
        send_item({1'b1, {(VW-1){1'b0}}}, 1'b1, 1'b1);
        wait_drained();
    endtask

    // The signed extremes, zero, minus one and a repeated value in scrambled order. The
    // last item carries a value, which must be inserted before the emission starts.
    task automatic test_extremes();
        send_item({1'b0, {(VW-1){1'b1}}}, 1'b1, 1'b0);
        send_item('1, 1'b1, 1'b0);
        send_item({1'b1, {(VW-1){1'b0}}}, 1'b1, 1'b0);
        send_item('0, 1'b1, 1'b0);
        send_item('1, 1'b1, 1'b1);
        wait_drained();
    endtask

    // Fills the store completely; the value on the closing item no longer fits and must
    // be dropped, which raises the overflow flag on every result of the set.
    task automatic test_overflow();
        for (int i = 0; i < CAPACITY; i++)
        begin
            send_item(VW'(CAPACITY - i) ^ (i[0] ? '1 : '0), 1'b1, 1'b0);
        end
        send_item(32'h0000_0042, 1'b1, 1'b1);
        wait_drained();
    endtask

    // Random sets. Most are well formed with random sizes and contents; a few are empty,
    // overflow, or carry ignored items between their values, which do not count.
    task automatic test_random_sets();
        int sent;
        int set_size;
        bit close_with_value;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 19)) inside
                0:       set_size = 0;
                [1:2]:   set_size = $urandom_range(9, CAPACITY);
                3:       set_size = $urandom_range(CAPACITY + 1, CAPACITY + 4);
                default: set_size = $urandom_range(1, 8);
            endcase
            close_with_value = (set_size != 0) && ($urandom_range(0, 1) == 1);
            for (int i = 0; i < set_size; i++)
            begin
                if ($urandom_range(0, 11) == 0)
                begin
                    send_item($urandom, 1'b0, 1'b0);
                end
                send_item(random_value(), 1'b1, close_with_value && (i == set_size - 1));
                sent++;
            end
            if (!close_with_value)
            begin
                send_item($urandom, 1'b0, 1'b1);
                sent++;
            end
            if ($urandom_range(0, 9) == 0)
            begin
                wait_drained();
            end
        end
        wait_drained();
    endtask

    task automatic check_field(input string name, input logic [VW-1:0] exp_val,
                               input logic [VW-1:0] act_val);
        if (exp_val !== act_val)
        begin
            $error("%s mismatch: expected %h, got %h", name, exp_val, act_val);
            mismatches++;
        end
    endtask

    // Every strobe is one result transfer; it is compared with the oldest owed result.
    // Outputs are read at the rising edge, before any update of that edge lands.
    always @(posedge clk)
    begin
        sorted_result_t want;
        if (rst_n && strobe)
        begin
            if (pending_sorted.size() == 0)
            begin
                $error("result transfer with no result owed: value %h", sorted_value);
                mismatches++;
            end
            else
            begin
                want = pending_sorted.pop_front();
                check_field("sorted_value", want.sorted_value, sorted_value);
                check_field("has_element", VW'(want.has_element), VW'(has_element));
                check_field("final_result", VW'(want.final_result), VW'(final_result));
                check_field("pass_count", VW'(want.pass_count), VW'(pass_count));
                check_field("overflowed", VW'(want.overflowed), VW'(overflowed));
            end
        end
    end

    // Watchdog: counts cycles in which neither an item nor a result moves.
    always @(posedge clk)
    begin
        if ((start && !busy && rst_n) || strobe)
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles + 1 >= STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_set();
        test_single_value();
        test_extremes();
        test_overflow();
        test_random_sets();

        // Nothing is owed any more; give the block time to show any stray result.
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/isort_pkg.sv
hw/rtl/isort_ctrl.sv
hw/rtl/isort_dp.sv
hw/rtl/insertion_sorter.sv
sim/tb_insertion_sorter.sv
